/* src/servo_instruction_packet_framer_core_defines.svh */
// Assertion macros shared by the servo packet framer RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef SERVO_INSTRUCTION_PACKET_FRAMER_CORE_DEFINES_SVH
`define SERVO_INSTRUCTION_PACKET_FRAMER_CORE_DEFINES_SVH

// Property that must hold at every clock edge out of reset.
`define SIPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true out of reset.
`define SIPF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

/* src/sipf_pkg.sv */
// Shared types and constants of the servo packet framer.
// No dependencies; used by every module of the framer.
`default_nettype none

package sipf_pkg;

  // Command codes
  localparam logic [2:0] CmdTorqueOff = 3'd0;
  localparam logic [2:0] CmdTorqueOn  = 3'd1;
  localparam logic [2:0] CmdCurMode   = 3'd2;
  localparam logic [2:0] CmdWriteCur  = 3'd3;
  localparam logic [2:0] CmdSyncWrite = 3'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;

  // Packet constants
  localparam logic [7:0] HdrFF       = 8'hFF;
  localparam logic [7:0] HdrFD       = 8'hFD;
  localparam logic [7:0] Zero8       = 8'h00;
  localparam logic [7:0] BcastId     = 8'hFE;
  localparam logic [7:0] InstrWrite  = 8'h03;
  localparam logic [7:0] InstrSync   = 8'h83;
  localparam logic [7:0] AddrTorque  = 8'h40;
  localparam logic [7:0] AddrMode    = 8'h0B;
  localparam logic [7:0] AddrCurrent = 8'h66;
  localparam logic [7:0] LenReg      = 8'h06;
  localparam logic [7:0] LenCur      = 8'h07;
  localparam logic [7:0] LenSync     = 8'h0D;
  localparam logic [7:0] SyncSize    = 8'h02;
  localparam logic [15:0] CrcPoly    = 16'h8005;

  // Byte positions
  localparam int unsigned IdxW = 5;
  localparam logic [IdxW-1:0] LastReg  = 5'd12;
  localparam logic [IdxW-1:0] LastCur  = 5'd13;
  localparam logic [IdxW-1:0] LastSync = 5'd19;

  // Command queue
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef enum logic [1:0] {
    KindReg  = 2'd0,
    KindCur  = 2'd1,
    KindSync = 2'd2
  } kind_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  servo_id;
    logic signed [15:0] current_a;
    logic signed [15:0] current_b;
  } in_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_rsp_t;

  // One classified command as handed to the back end
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  id;
    logic [7:0]  len;
    logic [7:0]  instr;
    logic [7:0]  addr;
    logic [7:0]  val;
    logic [15:0] ca;
    logic [15:0] cb;
    logic [7:0]  id1;
    logic [7:0]  id2;
  } desc_t;

endpackage

`default_nettype wire

/* src/servo_instruction_packet_framer_core.sv */
// Top level of the servo-bus instruction packet framer.
// Depends on sipf_pkg, sipf_front, sipf_queue and sipf_back.
//
//   port group  dir  handshake            payload
//   in          in   in_valid_i/stall_o   in_req_i  (cmd, servo_id, current_a, current_b)
//   out         out  out_valid_o/stall_i  out_rsp_o (tx_byte, last)
//   cfg         in   cfg_valid_i/ready_o  cfg_index_i, cfg_data_i
//
// One packet byte leaves per cycle unless the output stalls: a packet is 13 (torque,
// current mode), 14 (write current) or 20 (sync write) bytes long, set by the back end's
// byte sequencer and its bytewise CRC-16 update.
// Reset loads sync IDs 10 and 11 and empties the two-entry command queue.
// Output stalls hold the back end; the front keeps taking commands until
// the queue is full. Unused command codes are taken and dropped.
`default_nettype none

module servo_instruction_packet_framer_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sipf_pkg::in_req_t            in_req_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output sipf_pkg::out_rsp_t                out_rsp_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sipf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i
);

  // Front to queue
  logic            push;
  sipf_pkg::desc_t push_desc;
  logic            q_full;

  // Queue to back
  logic            head_valid;
  sipf_pkg::desc_t head;
  logic            pop;

  // Accept a request, snapshot the sync IDs, classify
  sipf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_desc_o (push_desc)
  );

  // Decouple the request side from the byte stream
  sipf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_desc_i  (push_desc),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Stream packet bytes with CRC; drop the descriptor after the last byte
  sipf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_rsp_o    (out_rsp_o)
  );

endmodule

`default_nettype wire

/* src/sipf_front.sv */
// Front end: accepts commands, holds the sync IDs, classifies into descriptors.
// Depends on sipf_pkg.
`default_nettype none

module sipf_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sipf_pkg::in_req_t            in_req_i,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [sipf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [7:0]                   cfg_data_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output sipf_pkg::desc_t                   push_desc_o
);

  logic [7:0] sync_first_q, sync_first_d;
  logic [7:0] sync_second_q, sync_second_d;
  logic       known;
  logic       accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign accept      = in_valid_i && !q_full_i;

  always_comb begin
    sync_first_d  = sync_first_q;
    sync_second_d = sync_second_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == sipf_pkg::CfgSyncFirst) begin
        sync_first_d = cfg_data_i;
      end else if (cfg_index_i == sipf_pkg::CfgSyncSecond) begin
        sync_second_d = cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'd10;
      sync_second_q <= 8'd11;
    end else begin
      sync_first_q  <= sync_first_d;
      sync_second_q <= sync_second_d;
    end
  end

  // Classify; unused codes are taken and dropped
  always_comb begin
    push_desc_o.kind  = sipf_pkg::KindReg;
    push_desc_o.id    = in_req_i.servo_id;
    push_desc_o.len   = sipf_pkg::LenReg;
    push_desc_o.instr = sipf_pkg::InstrWrite;
    push_desc_o.addr  = sipf_pkg::AddrTorque;
    push_desc_o.val   = sipf_pkg::Zero8;
    push_desc_o.ca    = in_req_i.current_a;
    push_desc_o.cb    = in_req_i.current_b;
    push_desc_o.id1   = sync_first_q;
    push_desc_o.id2   = sync_second_q;
    known             = 1'b1;
    unique case (in_req_i.cmd)
      sipf_pkg::CmdTorqueOff: begin
      end
      sipf_pkg::CmdTorqueOn: begin
        push_desc_o.val = 8'h01;
      end
      sipf_pkg::CmdCurMode: begin
        push_desc_o.addr = sipf_pkg::AddrMode;
      end
      sipf_pkg::CmdWriteCur: begin
        push_desc_o.kind = sipf_pkg::KindCur;
        push_desc_o.len  = sipf_pkg::LenCur;
        push_desc_o.addr = sipf_pkg::AddrCurrent;
      end
      sipf_pkg::CmdSyncWrite: begin
        push_desc_o.kind  = sipf_pkg::KindSync;
        push_desc_o.id    = sipf_pkg::BcastId;
        push_desc_o.len   = sipf_pkg::LenSync;
        push_desc_o.instr = sipf_pkg::InstrSync;
        push_desc_o.addr  = sipf_pkg::AddrCurrent;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign push_o = accept && known;

endmodule

`default_nettype wire

/* src/sipf_queue.sv */
// Two-entry descriptor queue between front and back end.
// Depends on sipf_pkg and the assertion macro header.
`default_nettype none

`include "servo_instruction_packet_framer_core_defines.svh"

module sipf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sipf_pkg::desc_t push_desc_i,
  output logic                 full_o,
  output logic                 head_valid_o,
  output sipf_pkg::desc_t      head_o,
  input  wire logic            pop_i
);

  sipf_pkg::desc_t                 mem_q [sipf_pkg::QDepth];
  logic [sipf_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [sipf_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [sipf_pkg::QCntW-1:0]      count_q, count_d;

  assign full_o       = (count_q == sipf_pkg::QCntW'(sipf_pkg::QDepth));
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  `SIPF_NEVER(a_no_overflow, push_i && full_o, "push into full command queue")
  `SIPF_NEVER(a_no_underflow, pop_i && !head_valid_o, "pop from empty command queue")

endmodule

`default_nettype wire

/* src/sipf_back.sv */
// Back end: walks one descriptor byte by byte, runs the CRC, feeds the output register.
// Depends on sipf_pkg and the assertion macro header.
`default_nettype none

`include "servo_instruction_packet_framer_core_defines.svh"

module sipf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            head_valid_i,
  input  wire sipf_pkg::desc_t head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output sipf_pkg::out_rsp_t   out_rsp_o
);

  logic [sipf_pkg::IdxW-1:0] idx_q, idx_d;
  logic [15:0]               crc_q, crc_d;
  logic                      out_valid_q, out_valid_d;
  sipf_pkg::out_rsp_t        out_q, out_d;
  logic                      adv;
  logic                      fire;
  logic [sipf_pkg::IdxW-1:0] last_idx;
  logic [7:0]                body_byte;
  logic [7:0]                sel_byte;
  logic                      is_crc;
  logic                      is_last;

  function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
    logic [15:0] r;
    int          k;
    r = c ^ {b, 8'h00};
    for (k = 0; k < 8; k++) begin
      r = r[15] ? ((r << 1) ^ sipf_pkg::CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  // Advance when the output slot is free or being emptied
  assign adv  = !out_valid_q || !out_stall_i;
  assign fire = adv && head_valid_i;

  always_comb begin
    unique case (head_i.kind)
      sipf_pkg::KindReg:  last_idx = sipf_pkg::LastReg;
      sipf_pkg::KindCur:  last_idx = sipf_pkg::LastCur;
      default:            last_idx = sipf_pkg::LastSync;
    endcase
  end

  always_comb begin
    body_byte = sipf_pkg::Zero8;
    unique case (idx_q)
      5'd0, 5'd1: body_byte = sipf_pkg::HdrFF;
      5'd2:       body_byte = sipf_pkg::HdrFD;
      5'd3:       body_byte = sipf_pkg::Zero8;
      5'd4:       body_byte = head_i.id;
      5'd5:       body_byte = head_i.len;
      5'd6:       body_byte = sipf_pkg::Zero8;
      5'd7:       body_byte = head_i.instr;
      5'd8:       body_byte = head_i.addr;
      5'd9:       body_byte = sipf_pkg::Zero8;
      5'd10: begin
        unique case (head_i.kind)
          sipf_pkg::KindReg: body_byte = head_i.val;
          sipf_pkg::KindCur: body_byte = head_i.ca[7:0];
          default:           body_byte = sipf_pkg::SyncSize;
        endcase
      end
      5'd11: body_byte = (head_i.kind == sipf_pkg::KindCur) ? head_i.ca[15:8]
                                                             : sipf_pkg::Zero8;
      5'd12:   body_byte = head_i.id1;
      5'd13:   body_byte = head_i.ca[7:0];
      5'd14:   body_byte = head_i.ca[15:8];
      5'd15:   body_byte = head_i.id2;
      5'd16:   body_byte = head_i.cb[7:0];
      5'd17:   body_byte = head_i.cb[15:8];
      default: body_byte = sipf_pkg::Zero8;
    endcase
  end

  // Replace the tail with the CRC, low byte first
  always_comb begin
    is_last = (idx_q == last_idx);
    is_crc  = is_last || (idx_q == last_idx - 1'b1);
    if (is_last) begin
      sel_byte = crc_q[15:8];
    end else if (is_crc) begin
      sel_byte = crc_q[7:0];
    end else begin
      sel_byte = body_byte;
    end
  end

  always_comb begin
    idx_d       = idx_q;
    crc_d       = crc_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (fire) begin
      out_valid_d   = 1'b1;
      out_d.tx_byte = sel_byte;
      out_d.last    = is_last;
      if (is_last) begin
        idx_d = '0;
        crc_d = '0;
        pop_o = 1'b1;
      end else begin
        idx_d = idx_q + 1'b1;
        if (!is_crc) begin
          crc_d = crc_step(crc_q, sel_byte);
        end
      end
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      crc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      crc_q       <= crc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SIPF_ASSERT(a_idx_range, (idx_q <= sipf_pkg::LastSync), "byte index past longest packet")
  `SIPF_ASSERT(a_crc_clear, (idx_q == '0) |-> (crc_q == '0), "CRC not cleared at packet start")
  `SIPF_ASSERT(a_last_wraps, (out_valid_q && out_q.last) |-> (idx_q == '0), "index not rewound")

endmodule

`default_nettype wire
